>>> sv/spectral_peak_picker_top_assert.svh
// Assertion macros for the spectral peak picker.
`ifndef SPECTRAL_PEAK_PICKER_TOP_ASSERT_SVH
`define SPECTRAL_PEAK_PICKER_TOP_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define SPP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("spectral peak picker check failed");

// Check that cons holds in the cycle after ante.
`define SPP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("spectral peak picker check failed");

`endif

>>> sv/spp_pkg.sv
package spp_pkg;

  localparam int MAX_BINS   = 4096;
  localparam int BIN_AW     = 12;
  localparam int CNT_W      = 13;
  localparam int MAX_PEAKS  = 16;
  localparam int SLOT_AW    = 4;
  localparam int PEAK_W     = 5;
  localparam int WINDOW     = 10;
  localparam int LOOKAHEAD  = WINDOW / 2;
  localparam int MIN_SEP    = 3;
  localparam int MAG_W      = 24;
  localparam int SCORE_W    = 28;
  localparam int STEP_W     = 16;
  localparam int FREQ_W     = 28;
  localparam int CFG_AW     = 3;
  localparam int CFG_DW     = 24;

  localparam logic [CFG_AW-1:0] REG_NUM_BINS      = 3'd0;
  localparam logic [CFG_AW-1:0] REG_NUM_PEAKS     = 3'd1;
  localparam logic [CFG_AW-1:0] REG_MIN_SCORE     = 3'd2;
  localparam logic [CFG_AW-1:0] REG_MIN_MAGNITUDE = 3'd3;
  localparam logic [CFG_AW-1:0] REG_BIN_FREQ_STEP = 3'd4;

  typedef enum logic [9:0] {
    ST_LOAD   = 10'b0000000001,
    ST_SC_RD  = 10'b0000000010,
    ST_SC_ACC = 10'b0000000100,
    ST_SC_WR  = 10'b0000001000,
    ST_PS_RD  = 10'b0000010000,
    ST_PS_CAP = 10'b0000100000,
    ST_CN_RD  = 10'b0001000000,
    ST_CN_CMP = 10'b0010000000,
    ST_CN_DEC = 10'b0100000000,
    ST_REPORT = 10'b1000000000
  } state_t;

endpackage

>>> sv/spp_in_if.sv
interface spp_in_if;
  logic                         valid;
  logic                         ready;
  logic [spp_pkg::MAG_W-1:0]    magnitude;
  logic                         frame_absent;

  modport source (output valid, output magnitude, output frame_absent, input ready);
  modport sink   (input valid, input magnitude, input frame_absent, output ready);
endinterface

>>> sv/spp_out_if.sv
interface spp_out_if;
  logic                          valid;
  logic                          ready;
  logic [spp_pkg::SLOT_AW-1:0]   slot;
  logic [spp_pkg::BIN_AW-1:0]    peak_bin;
  logic [spp_pkg::FREQ_W-1:0]    peak_freq;
  logic [spp_pkg::MAG_W-1:0]     peak_mag;
  logic                          last_peak;

  modport source (output valid, output slot, output peak_bin, output peak_freq,
                  output peak_mag, output last_peak, input ready);
  modport sink   (input valid, input slot, input peak_bin, input peak_freq,
                  input peak_mag, input last_peak, output ready);
endinterface

>>> sv/spectral_peak_picker_top.sv
// Flow: a word completing a frame of n bins starts the score pass, slot prefetch,
//   candidate scan and report in turn; one word per cycle while loading.
// Score pass: read, accumulate and write states per bin; slot scan: read, compare
//   against each active slot, then decide, per candidate; p words are reported (p = active peak slots).
// Reset: synchronous active-low; clears configuration, state, counters, slot bins and magnitudes and output valid.
//   The bin memories need no clearing pass; they are written before being read.
`include "spectral_peak_picker_top_assert.svh"

module spectral_peak_picker_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [spp_pkg::CFG_AW-1:0]    cfg_index,
  input  logic [spp_pkg::CFG_DW-1:0]    cfg_data,
  spp_in_if.sink                        in_ch,
  spp_out_if.source                     out_ch
);

  // Configuration registers
  logic [spp_pkg::CNT_W-1:0]   num_bins_r;
  logic [spp_pkg::PEAK_W-1:0]  num_peaks_r;
  logic [spp_pkg::MAG_W-1:0]   min_score_r;
  logic [spp_pkg::MAG_W-1:0]   min_mag_r;
  logic [spp_pkg::STEP_W-1:0]  step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_bins_r  <= spp_pkg::CNT_W'(1024);
      num_peaks_r <= spp_pkg::PEAK_W'(4);
      min_score_r <= '0;
      min_mag_r   <= spp_pkg::MAG_W'(2560);
      step_r      <= spp_pkg::STEP_W'(5507);
    end else if (cfg_we) begin
      case (cfg_index)
        spp_pkg::REG_NUM_BINS:      num_bins_r  <= cfg_data[spp_pkg::CNT_W-1:0];
        spp_pkg::REG_NUM_PEAKS:     num_peaks_r <= cfg_data[spp_pkg::PEAK_W-1:0];
        spp_pkg::REG_MIN_SCORE:     min_score_r <= cfg_data;
        spp_pkg::REG_MIN_MAGNITUDE: min_mag_r   <= cfg_data;
        spp_pkg::REG_BIN_FREQ_STEP: step_r      <= cfg_data[spp_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp counts to their usable range
  logic [spp_pkg::CNT_W-1:0]  n_act;
  logic [spp_pkg::PEAK_W-1:0] np_act;

  always_comb begin
    if (num_bins_r == '0)
      n_act = spp_pkg::CNT_W'(1);
    else if (num_bins_r > spp_pkg::CNT_W'(spp_pkg::MAX_BINS))
      n_act = spp_pkg::CNT_W'(spp_pkg::MAX_BINS);
    else
      n_act = num_bins_r;
    if (num_peaks_r == '0)
      np_act = spp_pkg::PEAK_W'(1);
    else if (num_peaks_r > spp_pkg::PEAK_W'(spp_pkg::MAX_PEAKS))
      np_act = spp_pkg::PEAK_W'(spp_pkg::MAX_PEAKS);
    else
      np_act = num_peaks_r;
  end

  spp_pkg::state_t state_r;

  logic [spp_pkg::CNT_W-1:0]   bin_cnt_r;
  logic [spp_pkg::CNT_W-1:0]   i_r;
  logic [spp_pkg::CNT_W-1:0]   scan_i_r;
  logic [spp_pkg::PEAK_W-1:0]  k_r;
  logic [spp_pkg::SCORE_W-1:0] w_r;
  logic [spp_pkg::SCORE_W-1:0] h0_r, h1_r, h2_r, h3_r, h4_r;
  logic [spp_pkg::SCORE_W-1:0] weak_r;
  logic [spp_pkg::SLOT_AW-1:0] weak_slot_r;
  logic                        member_r;

  logic [spp_pkg::BIN_AW-1:0]  slot_bin_r   [spp_pkg::MAX_PEAKS];
  logic [spp_pkg::MAG_W-1:0]   slot_mag_r   [spp_pkg::MAX_PEAKS];
  logic [spp_pkg::SCORE_W-1:0] slot_score_r [spp_pkg::MAX_PEAKS];

  // Bin memories
  logic [spp_pkg::MAG_W-1:0]   mag_mem   [spp_pkg::MAX_BINS];
  logic [spp_pkg::SCORE_W-1:0] score_mem [spp_pkg::MAX_BINS];
  logic [spp_pkg::MAG_W-1:0]   mag_a_r, mag_b_r;
  logic [spp_pkg::SCORE_W-1:0] sc_rd_r;

  logic                        in_acc;
  logic                        mag_we, sc_we;
  logic [spp_pkg::BIN_AW-1:0]  mag_ra, mag_rb, sc_ra;
  logic [spp_pkg::SCORE_W-1:0] score_val;
  logic [spp_pkg::SLOT_AW-1:0] k_idx;
  logic [spp_pkg::CNT_W-1:0]   slot_pos;
  logic [spp_pkg::CNT_W-1:0]   cn_pos;

  assign in_ch.ready = (state_r == spp_pkg::ST_LOAD);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign mag_we      = in_acc && !in_ch.frame_absent;
  assign sc_we       = (state_r == spp_pkg::ST_SC_WR);
  assign k_idx       = k_r[spp_pkg::SLOT_AW-1:0];
  assign slot_pos    = {1'b0, slot_bin_r[k_idx]} + spp_pkg::CNT_W'(spp_pkg::LOOKAHEAD);
  assign cn_pos      = scan_i_r + spp_pkg::CNT_W'(spp_pkg::LOOKAHEAD);
  assign mag_ra      = (state_r == spp_pkg::ST_SC_RD) ? i_r[spp_pkg::BIN_AW-1:0]
                                                      : scan_i_r[spp_pkg::BIN_AW-1:0];
  assign mag_rb      = i_r[spp_pkg::BIN_AW-1:0] - spp_pkg::BIN_AW'(spp_pkg::WINDOW);
  assign sc_ra       = (state_r == spp_pkg::ST_PS_RD) ? slot_pos[spp_pkg::BIN_AW-1:0]
                                                      : cn_pos[spp_pkg::BIN_AW-1:0];

  always_ff @(posedge clk) begin
    if (mag_we)
      mag_mem[bin_cnt_r[spp_pkg::BIN_AW-1:0]] <= in_ch.magnitude;
    mag_a_r <= mag_mem[mag_ra];
    mag_b_r <= mag_mem[mag_rb];
  end

  always_ff @(posedge clk) begin
    if (sc_we)
      score_mem[i_r[spp_pkg::BIN_AW-1:0]] <= score_val;
    sc_rd_r <= score_mem[sc_ra];
  end

  // Score of the current bin from the W history
  logic                        gt1, lt1, gt2, lt2, differ;
  logic [spp_pkg::SCORE_W:0]   sum_a, sum_b, sdiff;

  always_comb begin
    gt1    = h1_r > h2_r;
    lt1    = h1_r < h2_r;
    gt2    = h2_r > h3_r;
    lt2    = h2_r < h3_r;
    differ = (gt1 != gt2) || (lt1 != lt2);
    sum_a  = {1'b0, h1_r} + {1'b0, h3_r};
    sum_b  = {1'b0, h0_r} + {1'b0, h4_r};
    sdiff  = sum_a - sum_b;
    if (i_r >= spp_pkg::CNT_W'(3) && differ && sum_a > sum_b)
      score_val = sdiff[spp_pkg::SCORE_W] ? '1 : sdiff[spp_pkg::SCORE_W-1:0];
    else
      score_val = '0;
  end

  // Candidate checks
  logic [spp_pkg::CNT_W-1:0] sep;
  logic                      take;

  always_comb begin
    if ({1'b0, slot_bin_r[k_idx]} > scan_i_r)
      sep = {1'b0, slot_bin_r[k_idx]} - scan_i_r;
    else
      sep = scan_i_r - {1'b0, slot_bin_r[k_idx]};
    take = (sc_rd_r >= {4'b0, min_score_r}) && (sc_rd_r > weak_r) && !member_r &&
           (mag_a_r > min_mag_r);
  end

  // Output register
  logic                          out_load;
  logic                          out_valid_r;
  logic [spp_pkg::SLOT_AW-1:0]   out_slot_r;
  logic [spp_pkg::BIN_AW-1:0]    out_bin_r;
  logic [spp_pkg::FREQ_W-1:0]    out_freq_r;
  logic [spp_pkg::MAG_W-1:0]     out_mag_r;
  logic                          out_last_r;

  assign out_load = (state_r == spp_pkg::ST_REPORT) && (!out_valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_slot_r <= k_idx;
      out_bin_r  <= slot_bin_r[k_idx];
      out_freq_r <= spp_pkg::FREQ_W'(slot_bin_r[k_idx]) * spp_pkg::FREQ_W'(step_r);
      out_mag_r  <= slot_mag_r[k_idx];
      out_last_r <= (k_r + spp_pkg::PEAK_W'(1)) == np_act;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.slot      = out_slot_r;
  assign out_ch.peak_bin  = out_bin_r;
  assign out_ch.peak_freq = out_freq_r;
  assign out_ch.peak_mag  = out_mag_r;
  assign out_ch.last_peak = out_last_r;

  // Sequencer: load, score pass, slot prefetch, candidate scan, report; a frame-absent word skips to report
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= spp_pkg::ST_LOAD;
      bin_cnt_r <= '0;
      i_r       <= '0;
      scan_i_r  <= '0;
      k_r       <= '0;
      member_r  <= 1'b0;
      for (int s = 0; s < spp_pkg::MAX_PEAKS; s++) begin
        slot_bin_r[s] <= '0;
        slot_mag_r[s] <= '0;
      end
    end else begin
      case (state_r)
        spp_pkg::ST_LOAD: begin
          if (in_acc) begin
            if (in_ch.frame_absent) begin
              bin_cnt_r <= '0;
              k_r       <= '0;
              state_r   <= spp_pkg::ST_REPORT;
            end else if (bin_cnt_r + spp_pkg::CNT_W'(1) >= n_act) begin
              bin_cnt_r <= '0;
              i_r       <= '0;
              w_r       <= '0;
              h0_r      <= '0;
              h1_r      <= '0;
              h2_r      <= '0;
              h3_r      <= '0;
              h4_r      <= '0;
              state_r   <= spp_pkg::ST_SC_RD;
            end else begin
              bin_cnt_r <= bin_cnt_r + spp_pkg::CNT_W'(1);
            end
          end
        end
        spp_pkg::ST_SC_RD: begin
          state_r <= spp_pkg::ST_SC_ACC;
        end
        spp_pkg::ST_SC_ACC: begin
          // advance the running window and the history
          if (i_r >= spp_pkg::CNT_W'(spp_pkg::WINDOW))
            h0_r <= w_r + {4'b0, mag_a_r} - {4'b0, mag_b_r};
          else
            h0_r <= w_r + {4'b0, mag_a_r};
          if (i_r >= spp_pkg::CNT_W'(spp_pkg::WINDOW))
            w_r <= w_r + {4'b0, mag_a_r} - {4'b0, mag_b_r};
          else
            w_r <= w_r + {4'b0, mag_a_r};
          h1_r    <= h0_r;
          h2_r    <= h1_r;
          h3_r    <= h2_r;
          h4_r    <= h3_r;
          state_r <= spp_pkg::ST_SC_WR;
        end
        spp_pkg::ST_SC_WR: begin
          if (i_r + spp_pkg::CNT_W'(1) == n_act) begin
            k_r     <= '0;
            state_r <= spp_pkg::ST_PS_RD;
          end else begin
            i_r     <= i_r + spp_pkg::CNT_W'(1);
            state_r <= spp_pkg::ST_SC_RD;
          end
        end
        spp_pkg::ST_PS_RD: begin
          state_r <= spp_pkg::ST_PS_CAP;
        end
        spp_pkg::ST_PS_CAP: begin
          // hold each slot's score for the scan
          slot_score_r[k_idx] <= (slot_pos < n_act) ? sc_rd_r : '0;
          if (k_r + spp_pkg::PEAK_W'(1) == np_act) begin
            k_r      <= '0;
            scan_i_r <= '0;
            if ({1'b0, n_act} > (spp_pkg::CNT_W+1)'(spp_pkg::LOOKAHEAD))
              state_r <= spp_pkg::ST_CN_RD;
            else
              state_r <= spp_pkg::ST_REPORT;
          end else begin
            k_r     <= k_r + spp_pkg::PEAK_W'(1);
            state_r <= spp_pkg::ST_PS_RD;
          end
        end
        spp_pkg::ST_CN_RD: begin
          k_r      <= '0;
          member_r <= 1'b0;
          state_r  <= spp_pkg::ST_CN_CMP;
        end
        spp_pkg::ST_CN_CMP: begin
          // walk the slots: separation and weakest score
          if (sep < spp_pkg::CNT_W'(spp_pkg::MIN_SEP))
            member_r <= 1'b1;
          if (k_r == '0 || slot_score_r[k_idx] < weak_r) begin
            weak_r      <= slot_score_r[k_idx];
            weak_slot_r <= k_idx;
          end
          if (k_r + spp_pkg::PEAK_W'(1) == np_act)
            state_r <= spp_pkg::ST_CN_DEC;
          else
            k_r <= k_r + spp_pkg::PEAK_W'(1);
        end
        spp_pkg::ST_CN_DEC: begin
          if (take) begin
            slot_bin_r[weak_slot_r]   <= scan_i_r[spp_pkg::BIN_AW-1:0];
            slot_mag_r[weak_slot_r]   <= mag_a_r;
            slot_score_r[weak_slot_r] <= sc_rd_r;
          end
          k_r      <= '0;
          scan_i_r <= scan_i_r + spp_pkg::CNT_W'(1);
          if (cn_pos + spp_pkg::CNT_W'(1) < n_act)
            state_r <= spp_pkg::ST_CN_RD;
          else
            state_r <= spp_pkg::ST_REPORT;
        end
        spp_pkg::ST_REPORT: begin
          if (out_load) begin
            if (k_r + spp_pkg::PEAK_W'(1) == np_act) begin
              k_r     <= '0;
              state_r <= spp_pkg::ST_LOAD;
            end else begin
              k_r <= k_r + spp_pkg::PEAK_W'(1);
            end
          end
        end
        default: state_r <= spp_pkg::ST_LOAD;
      endcase
    end
  end

  `SPP_ASSERT_NOW(a_report_in_range, state_r == spp_pkg::ST_REPORT, k_r < np_act)
  `SPP_ASSERT_NOW(a_scan_in_range, state_r == spp_pkg::ST_CN_RD, cn_pos < n_act)
  `SPP_ASSERT_NOW(a_score_in_range, state_r == spp_pkg::ST_SC_RD, i_r < n_act)
  `SPP_ASSERT_NEXT(a_dec_next, state_r == spp_pkg::ST_CN_DEC, state_r == spp_pkg::ST_CN_RD || state_r == spp_pkg::ST_REPORT)

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned SCORE_SAT = 32'h0FFF_FFFF;
  localparam int STALL_LIMIT = 400000;
  localparam int HOLD_CYCLES = 2500;

  typedef struct {
    logic [spp_pkg::MAG_W-1:0] magnitude;
    logic                      frame_absent;
  } bin_word_t;

  typedef struct {
    logic [spp_pkg::SLOT_AW-1:0] slot;
    logic [spp_pkg::BIN_AW-1:0]  peak_bin;
    logic [spp_pkg::FREQ_W-1:0]  peak_freq;
    logic [spp_pkg::MAG_W-1:0]   peak_mag;
    logic                        last_peak;
  } peak_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [spp_pkg::CFG_AW-1:0] cfg_index = '0;
  logic [spp_pkg::CFG_DW-1:0] cfg_data = '0;

  spp_in_if  in_ch ();
  spp_out_if out_ch ();

  spectral_peak_picker_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source)
  );

  always #1 clk = ~clk;

  // Known levels on every input from time zero
  initial begin
    in_ch.valid = 1'b0;
    in_ch.magnitude = '0;
    in_ch.frame_absent = 1'b0;
    out_ch.ready = 1'b0;
  end

  // Shadow configuration and state of the peak picker
  logic [12:0] sh_num_bins = 13'd1024;
  logic [4:0]  sh_num_peaks = 5'd4;
  logic [23:0] sh_min_score = '0;
  logic [23:0] sh_min_mag = 24'd2560;
  logic [15:0] sh_freq_step = 16'd5507;
  int unsigned frame_mag [spp_pkg::MAX_BINS];
  int unsigned bin_score [spp_pkg::MAX_BINS];
  int unsigned slot_bin [spp_pkg::MAX_PEAKS];
  int unsigned slot_mag [spp_pkg::MAX_PEAKS];
  int unsigned bins_loaded = 0;

  bin_word_t  bin_q [$];
  peak_word_t peak_q [$];
  int errors = 0;
  int idle_pct = 17;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;
  int hold_left = 0;
  int stall_cycles = 0;
  bin_word_t drv_word;
  peak_word_t exp_word;

  function automatic int unsigned active_bins();
    if (sh_num_bins == 0) return 1;
    if (sh_num_bins > spp_pkg::MAX_BINS) return spp_pkg::MAX_BINS;
    return sh_num_bins;
  endfunction

  function automatic int unsigned active_peaks();
    if (sh_num_peaks == 0) return 1;
    if (sh_num_peaks > spp_pkg::MAX_PEAKS) return spp_pkg::MAX_PEAKS;
    return sh_num_peaks;
  endfunction

  function automatic int sgn(longint v);
    return v > 0 ? 1 : (v < 0 ? -1 : 0);
  endfunction

  function automatic int unsigned score_at(int unsigned pos, int unsigned n);
    return pos < n ? bin_score[pos] : 0;
  endfunction

  // Score every bin, then scan candidates against the persistent slots
  function automatic void pick_peaks(int unsigned n);
    longint h [5];
    longint w;
    longint v;
    int unsigned i, k, np, score, cur, weakest, weak_slot, d;
    bit member;
    h = '{default: 0};
    w = 0;
    np = active_peaks();
    for (i = 0; i < n; i++) begin
      score = 0;
      w += frame_mag[i];
      if (i >= spp_pkg::WINDOW) w -= frame_mag[i - spp_pkg::WINDOW];
      h[4] = h[3]; h[3] = h[2]; h[2] = h[1]; h[1] = h[0]; h[0] = w;
      if (i >= 3 && sgn(h[1] - h[2]) != sgn(h[2] - h[3])) begin
        v = h[1] + h[3] - h[0] - h[4];
        if (v > 0) score = (v > SCORE_SAT) ? SCORE_SAT : int'(v);
      end
      bin_score[i] = score;
    end
    for (i = 0; i + spp_pkg::LOOKAHEAD < n; i++) begin
      cur = bin_score[i + spp_pkg::LOOKAHEAD];
      weakest = score_at(slot_bin[0] + spp_pkg::LOOKAHEAD, n);
      weak_slot = 0;
      member = 1'b0;
      for (k = 0; k < np; k++) begin
        d = slot_bin[k] > i ? slot_bin[k] - i : i - slot_bin[k];
        if (d < spp_pkg::MIN_SEP) member = 1'b1;
      end
      for (k = 1; k < np; k++) begin
        if (score_at(slot_bin[k] + spp_pkg::LOOKAHEAD, n) < weakest) begin
          weakest = score_at(slot_bin[k] + spp_pkg::LOOKAHEAD, n);
          weak_slot = k;
        end
      end
      if (cur >= sh_min_score && cur > weakest && !member && frame_mag[i] > sh_min_mag) begin
        slot_bin[weak_slot] = i;
        slot_mag[weak_slot] = frame_mag[i];
      end
    end
  endfunction

  // Queue one expected word per active slot
  function automatic void queue_report();
    int unsigned k, np;
    peak_word_t p;
    longint unsigned f;
    np = active_peaks();
    for (k = 0; k < np; k++) begin
      p.slot = k[spp_pkg::SLOT_AW-1:0];
      p.peak_bin = slot_bin[k][spp_pkg::BIN_AW-1:0];
      f = longint'(p.peak_bin) * longint'(sh_freq_step);
      p.peak_freq = f[spp_pkg::FREQ_W-1:0];
      p.peak_mag = slot_mag[k][spp_pkg::MAG_W-1:0];
      p.last_peak = (k + 1 == np);
      peak_q.push_back(p);
    end
  endfunction

  function automatic void predict_word(bin_word_t b);
    int unsigned n;
    n = active_bins();
    if (b.frame_absent) begin
      bins_loaded = 0;
      queue_report();
      return;
    end
    if (bins_loaded < spp_pkg::MAX_BINS) frame_mag[bins_loaded] = b.magnitude;
    bins_loaded++;
    if (bins_loaded < n) return;
    bins_loaded = 0;
    pick_peaks(n);
    queue_report();
  endfunction

  task automatic report_mismatch(string field, longint unsigned got, longint unsigned want);
    $display("mismatch on %s: got %0h, expected %0h at %0t", field, got, want, $realtime);
    errors++;
  endtask

  // Driver: offer the next bin word, hold it until accepted
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (bin_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
        drv_word = bin_q.pop_front();
        predict_word(drv_word);
        in_ch.valid <= 1'b1;
        in_ch.magnitude <= drv_word.magnitude;
        in_ch.frame_absent <= drv_word.frame_absent;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result ready: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // Monitor: check each accepted word against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (peak_q.size() == 0) begin
        report_mismatch("unexpected word, slot", out_ch.slot, 0);
      end else begin
        exp_word = peak_q.pop_front();
        if (out_ch.slot !== exp_word.slot)
          report_mismatch("slot", out_ch.slot, exp_word.slot);
        if (out_ch.peak_bin !== exp_word.peak_bin)
          report_mismatch("peak_bin", out_ch.peak_bin, exp_word.peak_bin);
        if (out_ch.peak_freq !== exp_word.peak_freq)
          report_mismatch("peak_freq", out_ch.peak_freq, exp_word.peak_freq);
        if (out_ch.peak_mag !== exp_word.peak_mag)
          report_mismatch("peak_mag", out_ch.peak_mag, exp_word.peak_mag);
        if (out_ch.last_peak !== exp_word.last_peak)
          report_mismatch("last_peak", out_ch.last_peak, exp_word.last_peak);
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
        $display("spectral_peak_picker_top test failed");
        $finish;
      end
    end
  end

  task automatic set_reg(logic [spp_pkg::CFG_AW-1:0] idx, int unsigned val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[spp_pkg::CFG_DW-1:0];
    case (idx)
      spp_pkg::REG_NUM_BINS:      sh_num_bins = val[12:0];
      spp_pkg::REG_NUM_PEAKS:     sh_num_peaks = val[4:0];
      spp_pkg::REG_MIN_SCORE:     sh_min_score = val[23:0];
      spp_pkg::REG_MIN_MAGNITUDE: sh_min_mag = val[23:0];
      spp_pkg::REG_BIN_FREQ_STEP: sh_freq_step = val[15:0];
      default: ;
    endcase
  endtask

  task automatic end_cfg();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait until all words are accepted and all results are back
  task automatic settle();
    while (bin_q.size() > 0 || in_ch.valid || peak_q.size() > 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic push_bin(int unsigned mag, bit absent);
    bin_word_t b;
    b.magnitude = mag[spp_pkg::MAG_W-1:0];
    b.frame_absent = absent;
    bin_q.push_back(b);
  endtask

  // Fill one frame: full-range noise or a low floor with sparse bumps
  task automatic push_frame(int unsigned n, bit full_range);
    int unsigned j;
    for (j = 0; j < n; j++) begin
      if (full_range) push_bin($urandom(), 1'b0);
      else if ($urandom_range(3) == 0) push_bin($urandom_range(1 << 20), 1'b0);
      else push_bin($urandom_range(4000), 1'b0);
    end
  endtask

  task automatic random_config();
    set_reg(spp_pkg::REG_NUM_BINS, ($urandom_range(9) == 0) ? $urandom_range(40, 160)
                                                             : $urandom_range(8, 24));
    set_reg(spp_pkg::REG_NUM_PEAKS, $urandom_range(31));
    set_reg(spp_pkg::REG_MIN_SCORE,
            ($urandom_range(7) == 0) ? $urandom() : $urandom_range(1 << 16));
    set_reg(spp_pkg::REG_MIN_MAGNITUDE,
            ($urandom_range(7) == 0) ? $urandom() : $urandom_range(1 << 14));
    set_reg(spp_pkg::REG_BIN_FREQ_STEP, $urandom_range(1, 65535));
    end_cfg();
  endtask

  initial begin
    int j, f, frames;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Report the cleared slots at reset settings
    push_bin(24'hFFFFFF, 1'b1);
    settle();

    // Eight-bin frame, single slot, extremes of the magnitude field
    set_reg(spp_pkg::REG_NUM_BINS, 8);
    set_reg(spp_pkg::REG_NUM_PEAKS, 1);
    set_reg(spp_pkg::REG_MIN_MAGNITUDE, 0);
    set_reg(spp_pkg::REG_BIN_FREQ_STEP, 65535);
    end_cfg();
    push_bin(0, 1'b0); push_bin(24'hFFFFFF, 1'b0); push_bin(0, 1'b0);
    push_bin(24'hFFFFFF, 1'b0); push_bin(24'h800000, 1'b0); push_bin(0, 1'b0);
    push_bin(24'hFFFFFF, 1'b0); push_bin(1, 1'b0);
    // Discard a partial frame
    push_bin(24'h123456, 1'b0); push_bin(24'h654321, 1'b0); push_bin(0, 1'b1);
    settle();

    // Zero slot and bin counts act as one; all slots, unit frequency step
    set_reg(spp_pkg::REG_NUM_BINS, 0);
    set_reg(spp_pkg::REG_NUM_PEAKS, 0);
    set_reg(spp_pkg::REG_BIN_FREQ_STEP, 1);
    end_cfg();
    push_bin(24'hABCDEF, 1'b0); push_bin(0, 1'b0);
    settle();
    set_reg(spp_pkg::REG_NUM_PEAKS, 31);
    set_reg(spp_pkg::REG_MIN_SCORE, 24'hFFFFFF);
    set_reg(spp_pkg::REG_MIN_MAGNITUDE, 24'hFFFFFF);
    set_reg(spp_pkg::REG_NUM_BINS, 12);
    end_cfg();
    push_frame(12, 1'b1);
    settle();

    // Lower the bin count mid-frame
    set_reg(spp_pkg::REG_NUM_BINS, 20);
    set_reg(spp_pkg::REG_MIN_SCORE, 0);
    set_reg(spp_pkg::REG_MIN_MAGNITUDE, 0);
    end_cfg();
    for (j = 0; j < 6; j++) push_bin($urandom_range(1 << 20), 1'b0);
    settle();
    set_reg(spp_pkg::REG_NUM_BINS, 4);
    end_cfg();
    push_bin(24'h00FF00, 1'b0);
    settle();

    // Oversized bin count: a short partial frame, then drop it
    set_reg(spp_pkg::REG_NUM_BINS, 8191);
    set_reg(spp_pkg::REG_NUM_PEAKS, 16);
    set_reg(spp_pkg::REG_BIN_FREQ_STEP, 5507);
    end_cfg();
    push_frame(10, 1'b0);
    push_bin(0, 1'b1);
    settle();

    // Back-pressure: many short frames while the result side holds off
    set_reg(spp_pkg::REG_NUM_BINS, 8);
    set_reg(spp_pkg::REG_NUM_PEAKS, 16);
    end_cfg();
    for (f = 0; f < 8; f++) push_frame(8, f[0]);
    hold_req <= 1'b1;
    settle();

    // Random phases; one runs with no idling at all
    for (j = 0; j < 8; j++) begin
      random_config();
      idle_pct = (j == 5) ? 0 : 17;
      frames = $urandom_range(1, 3);
      for (f = 0; f < frames; f++) begin
        if ($urandom_range(9) == 0) begin
          push_frame($urandom_range(1, 6), 1'b1);
          push_bin($urandom(), 1'b1);
        end else begin
          push_frame(active_bins(), $urandom_range(3) == 0);
        end
      end
      if ($urandom_range(4) == 0) push_bin($urandom(), 1'b1);
      settle();
    end

    if (errors == 0) begin
      $display("spectral_peak_picker_top test passed");
    end else begin
      $display("spectral_peak_picker_top test failed");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+sv
sv/spp_pkg.sv
sv/spp_in_if.sv
sv/spp_out_if.sv
sv/spectral_peak_picker_top.sv
bench/tb_top.sv
